[sv/inu_pkg.sv]
// ----------------------------------------------------------------------------
// inu_pkg
// Shared types and constants for the integer nearest-neighbor upscaler:
// request and result payloads, status codes and register indexes.
// ----------------------------------------------------------------------------
package inu_pkg;

  localparam int INU_MAX_WIDTH = 4096;
  localparam int INU_MAX_SCALE = 128;

  localparam int PIXEL_W = 24;
  localparam int SCALE_W = 8;
  localparam int SWIDTH_W = 13;
  localparam int CFG_DATA_W = 13;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_PIXEL    = 3'd0,
    ST_PAD      = 3'd1,
    ST_ACCEPT   = 3'd2,
    ST_REJECT   = 3'd3,
    ST_NOTREADY = 3'd4
  } status_t;

  typedef enum logic {
    CFG_SCALE_FACTOR = 1'b0,
    CFG_SOURCE_WIDTH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    op_t                op;
    logic [PIXEL_W-1:0] pixel_in;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [PIXEL_W-1:0] pixel_out;
    logic               end_of_line;
    logic               end_of_group;
  } result_t;

  // Pad bytes per output row for 24-bit pixels: (4 - 3*w*s mod 4) mod 4,
  // which works out to (w*s) mod 4.
  function automatic logic [1:0] pad_bytes(input logic [1:0] w_lo, input logic [1:0] s_lo);
    logic [3:0] prod;
    prod = 4'(w_lo) * 4'(s_lo);
    return prod[1:0];
  endfunction

endpackage

[sv/integer_nearest_upscaler.sv]
// ----------------------------------------------------------------------------
// integer_nearest_upscaler
// Nearest-neighbor upscaler for 24-bit pixels by a whole-number factor,
// built around a single-row line store.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on item/item_valid/item_stall. A load request writes one
//   source pixel into the line store; a tick request asks for the next output
//   item (pixel or pad byte). Every request yields exactly one result on
//   result/result_valid/result_stall, in order.
//   The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready and sets scale_factor and source_width; write it only while
//   no request is in flight.
//   A request's result is registered and shows in the cycle after it is
//   accepted. Throughput is one request per clock while the receiver does not
//   stall, set by one access to the line store per request (one write port
//   for loads, one registered read port for ticks).
//   When the receiver stalls a waiting result, item_stall rises and the
//   result and its store read data hold until taken.
//   Reset clears all counters and the output valid flag and sets both
//   registers to 1. The line store content is not cleared; every entry read
//   was written for the current source row.
// ----------------------------------------------------------------------------
module integer_nearest_upscaler
  import inu_pkg::*;
#(
  parameter int MAX_WIDTH = INU_MAX_WIDTH,
  parameter int MAX_SCALE = INU_MAX_SCALE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  item_t                 item,
  input  logic                  item_valid,
  output logic                  item_stall,
  output result_t               result,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW = $clog2(MAX_SCALE + 1);

  logic [PIXEL_W-1:0] line_store [MAX_WIDTH];
  logic [PIXEL_W-1:0] rd_data;

  logic [SCALE_W-1:0]  scale_factor;
  logic [SWIDTH_W-1:0] source_width;

  logic [CW-1:0] loaded_count, loaded_count_next;
  logic [CW-1:0] source_index, source_index_next;
  logic [SW-1:0] horizontal_repeat, horizontal_repeat_next;
  logic [SW-1:0] vertical_repeat, vertical_repeat_next;
  logic [1:0]    pad_count, pad_count_next;
  logic          in_padding, in_padding_next;

  status_t status_q, status_next;
  logic    eol_q, eol_next;
  logic    eog_q, eog_next;

  logic [CW-1:0] w_eff;
  logic [SW-1:0] s_eff;
  logic [1:0]    pad;
  logic [SW-1:0] hr_inc;
  logic [CW-1:0] si_inc;
  logic [SW-1:0] vr_inc;
  logic [2:0]    pc_inc;
  logic          item_acc;
  logic          store_wr;
  logic          store_rd;

  assign cfg_ready  = 1'b1;
  assign item_stall = result_valid && result_stall;
  assign item_acc   = item_valid && !item_stall;

  // Out-of-range register values are clamped into the supported range.
  always_comb begin
    if (source_width == '0) begin
      w_eff = CW'(1);
    end else if (32'(source_width) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(source_width);
    end
    if (scale_factor == '0) begin
      s_eff = SW'(1);
    end else if (32'(scale_factor) > 32'(MAX_SCALE)) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = SW'(scale_factor);
    end
  end

  assign pad    = pad_bytes(2'(w_eff), 2'(s_eff));
  assign hr_inc = horizontal_repeat + SW'(1);
  assign si_inc = source_index + CW'(1);
  assign vr_inc = vertical_repeat + SW'(1);

  always_comb begin
    loaded_count_next      = loaded_count;
    source_index_next      = source_index;
    horizontal_repeat_next = horizontal_repeat;
    vertical_repeat_next   = vertical_repeat;
    pad_count_next         = pad_count;
    in_padding_next        = in_padding;
    status_next            = ST_NOTREADY;
    eol_next               = 1'b0;
    eog_next               = 1'b0;
    store_wr               = 1'b0;
    store_rd               = 1'b0;
    pc_inc                 = 3'(pad_count) + 3'd1;

    unique case (item.op)
      OP_LOAD: begin
        if (loaded_count >= w_eff) begin
          status_next = ST_REJECT;
        end else begin
          status_next       = ST_ACCEPT;
          store_wr          = 1'b1;
          loaded_count_next = loaded_count + CW'(1);
        end
      end
      OP_TICK: begin
        if (!in_padding && source_index < w_eff) begin
          if (source_index >= loaded_count) begin
            status_next = ST_NOTREADY;
          end else begin
            status_next = ST_PIXEL;
            store_rd    = 1'b1;
            if (hr_inc >= s_eff) begin
              horizontal_repeat_next = '0;
              source_index_next      = si_inc;
              if (si_inc >= w_eff) begin
                if (pad == 2'd0) begin
                  eol_next = 1'b1;
                end else begin
                  in_padding_next = 1'b1;
                  pad_count_next  = '0;
                end
              end
            end else begin
              horizontal_repeat_next = hr_inc;
            end
          end
        end else begin
          // A row that ran past the width enters padding with a fresh count.
          if (!in_padding) begin
            pc_inc = 3'd1;
          end
          status_next     = ST_PAD;
          in_padding_next = 1'b1;
          if (pc_inc >= 3'(pad)) begin
            eol_next = 1'b1;
          end else begin
            pad_count_next = pc_inc[1:0];
          end
        end
        // Closing a row rewinds the replay; the last replay frees the store.
        if (eol_next) begin
          source_index_next      = '0;
          horizontal_repeat_next = '0;
          in_padding_next        = 1'b0;
          pad_count_next         = '0;
          if (vr_inc >= s_eff) begin
            vertical_repeat_next = '0;
            loaded_count_next    = '0;
            eog_next             = 1'b1;
          end else begin
            vertical_repeat_next = vr_inc;
          end
        end
      end
      default: begin
        status_next = ST_NOTREADY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_W'(1);
      source_width <= SWIDTH_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCALE_FACTOR: scale_factor <= cfg_data[SCALE_W-1:0];
        CFG_SOURCE_WIDTH: source_width <= cfg_data[SWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count      <= '0;
      source_index      <= '0;
      horizontal_repeat <= '0;
      vertical_repeat   <= '0;
      pad_count         <= '0;
      in_padding        <= 1'b0;
      result_valid      <= 1'b0;
    end else begin
      if (item_acc) begin
        loaded_count      <= loaded_count_next;
        source_index      <= source_index_next;
        horizontal_repeat <= horizontal_repeat_next;
        vertical_repeat   <= vertical_repeat_next;
        pad_count         <= pad_count_next;
        in_padding        <= in_padding_next;
        result_valid      <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      status_q <= status_next;
      eol_q    <= eol_next;
      eog_q    <= eog_next;
    end
  end

  // Line store: one write port for loads, one registered read port for ticks.
  // A pixel is always loaded at an earlier edge than the tick that reads it.
  always_ff @(posedge clk) begin
    if (item_acc && store_wr) begin
      line_store[loaded_count[AW-1:0]] <= item.pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc && store_rd) begin
      rd_data <= line_store[source_index[AW-1:0]];
    end
  end

  always_comb begin
    result.status       = status_q;
    result.pixel_out    = (status_q == ST_PIXEL) ? rd_data : '0;
    result.end_of_line  = eol_q;
    result.end_of_group = eog_q;
  end

endmodule

[sv/inu_checker.sv]
// ----------------------------------------------------------------------------
// inu_checker
// Port-level checks for the upscaler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module inu_checker
  import inu_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input result_t result,
  input logic    result_valid,
  input logic    result_stall
);

  // A waiting result holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // With no result waiting the block never pushes back on a request.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("request stalled with empty output register");

  // Pixel data is shown only with a pixel status.
  a_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_PIXEL |-> result.pixel_out == '0)
    else $error("nonzero pixel_out on a non-pixel result");

  // The end of a group is always the end of a row, and rows end on output items.
  a_group_is_line: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.end_of_group |-> result.end_of_line)
    else $error("end_of_group without end_of_line");

  a_line_on_output: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.end_of_line |->
      (result.status == ST_PIXEL || result.status == ST_PAD))
    else $error("end_of_line on a result that is not an output item");

endmodule

bind integer_nearest_upscaler inu_checker u_inu_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result       (result),
  .result_valid (result_valid),
  .result_stall (result_stall)
);
